[rtl/vscs_pkg.sv]
// shared types, constants and tables of the vehicle speed command shaper
package vscs_pkg;

	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 32;

	// item queue between front and back, a power of two
	localparam int QueueDepth = 2;
	localparam int QPtrW      = $clog2(QueueDepth);

	typedef enum logic [CfgIdxW-1:0] {
		REG_INV_WHEELBASE   = 3'd0,
		REG_MAX_STEER_ANGLE = 3'd1,
		REG_INV_MAX_SPEED   = 3'd2,
		REG_ACCEL_LIMIT     = 3'd3,
		REG_BRAKE_LIMIT     = 3'd4,
		REG_POSE_TIMEOUT    = 3'd5
	} reg_idx_t;

	localparam logic [15:0] InvWheelbaseRst  = 16'd985;
	localparam logic [14:0] MaxSteerAngleRst = 15'd7149;
	localparam logic [15:0] InvMaxSpeedRst   = 16'd4369;
	localparam logic [15:0] AccelLimitRst    = 16'd2560;
	localparam logic [15:0] BrakeLimitRst    = 16'd256;
	localparam logic [31:0] PoseTimeoutRst   = 32'd32768;

	localparam logic [16:0] AngleClamp   = 17'd100000;
	localparam logic [13:0] CoastFrac    = 14'd13107;
	localparam logic [17:0] DeltaSat     = 18'd131072;
	localparam logic [23:0] TanOverflow  = 24'd524288;
	localparam logic [33:0] CordicInitX  = 34'd1073741824;
	localparam int          CordicSteps  = 16;
	localparam int          SqrtSteps    = 16;
	localparam int          DivSteps     = 46;

	typedef struct packed {
		logic               command;
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic signed [15:0] throttle;
		logic signed [15:0] steering;
		logic [31:0]        stamp;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

	// atan(2^-i) in Q.16 rad
	function automatic logic [15:0] atan_lut(input logic [3:0] i);
		logic [15:0] r;
		case (i)
			4'd0:    r = 16'd51472;
			4'd1:    r = 16'd30386;
			4'd2:    r = 16'd16055;
			4'd3:    r = 16'd8150;
			4'd4:    r = 16'd4091;
			4'd5:    r = 16'd2047;
			4'd6:    r = 16'd1024;
			4'd7:    r = 16'd512;
			4'd8:    r = 16'd256;
			4'd9:    r = 16'd128;
			4'd10:   r = 16'd64;
			4'd11:   r = 16'd32;
			4'd12:   r = 16'd16;
			4'd13:   r = 16'd8;
			4'd14:   r = 16'd4;
			default: r = 16'd2;
		endcase
		return r;
	endfunction

endpackage

[rtl/vscs_ifs.sv]
// request channel interfaces of the vehicle speed command shaper
interface vscs_in_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic signed [15:0] vel_x;
	logic signed [15:0] vel_y;
	logic signed [15:0] throttle;
	logic signed [15:0] steering;
	logic [31:0]        stamp;

	modport source (output valid, command, vel_x, vel_y, throttle, steering, stamp,
		input ready);
	modport sink (input valid, command, vel_x, vel_y, throttle, steering, stamp,
		output ready);
endinterface

interface vscs_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] linear_velocity;
	logic signed [15:0] yaw_rate;

	modport source (output valid, linear_velocity, yaw_rate, input ready);
	modport sink (input valid, linear_velocity, yaw_rate, output ready);
endinterface

[rtl/vscs_front.sv]
// front end: accepts requests, tags their kind and queues them for the back end
module vscs_front (
	input  logic                  clk,
	input  logic                  arst_n,
	vscs_in_if.sink               in_ch,
	input  logic                  pop,
	output vscs_pkg::queue_head_t head
);
	import vscs_pkg::*;

	item_t            mem_q [QueueDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QPtrW:0]   count_q;
	logic             push;
	logic             pull;
	item_t            in_item;

	assign in_ch.ready = (count_q != QueueDepth[QPtrW:0]);
	assign push = in_ch.valid && in_ch.ready;
	assign pull = pop && (count_q != '0);

	// any nonzero command bit marks a throttle and steering request
	always_comb begin
		in_item.command  = (in_ch.command != 1'b0);
		in_item.vel_x    = in_ch.vel_x;
		in_item.vel_y    = in_ch.vel_y;
		in_item.throttle = in_ch.throttle;
		in_item.steering = in_ch.steering;
		in_item.stamp    = in_ch.stamp;
	end

	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pull) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pull) count_q <= count_q + 1'b1;
			else if (pull && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= in_item;
	end

endmodule

[rtl/vscs_core.sv]
// back end: pose speed, velocity integration, steering tan and yaw rate on one shared multiplier
module vscs_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  vscs_pkg::queue_head_t         head,
	output logic                          pop,
	input  logic                          cfg_we,
	input  logic [vscs_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [vscs_pkg::CfgDataW-1:0] cfg_data,
	vscs_out_if.source                    out_ch
);
	import vscs_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SQX, ST_SQY, ST_SUM, ST_SQRT, ST_PSAVE,
		ST_CHECK, ST_RATIO, ST_TERM, ST_MLO, ST_MHI, ST_DELTA,
		ST_DEC1, ST_DEC2, ST_DEC3,
		ST_ANG, ST_ANG2, ST_CORDIC, ST_DIVSET, ST_DIV,
		ST_YAW1, ST_YAW2, ST_YAW3, ST_EMIT
	} state_t;

	state_t state_q;

	// configuration
	logic [15:0] inv_wb_q;
	logic [14:0] max_steer_q;
	logic [15:0] inv_ms_q;
	logic [15:0] accel_q;
	logic [15:0] brake_q;
	logic [31:0] timeout_q;

	// persistent state
	logic signed [15:0] speed_q;
	logic [31:0]        pose_time_q;
	logic [31:0]        cmd_time_q;
	logic               awaiting_q;
	logic               pose_seen_q;

	// output register
	logic               out_valid_q;
	logic signed [15:0] out_vel_q;
	logic signed [15:0] out_yaw_q;

	// working registers
	item_t              item_q;
	logic [31:0]        dt_q;
	logic [63:0]        acc_q;
	logic [63:0]        prod_q;
	logic [37:0]        mag_q;
	logic               neg_q;
	logic signed [15:0] nv_q;
	logic [31:0]        n_q;
	logic [31:0]        res_q;
	logic [5:0]         iter_q;
	logic signed [33:0] cx_q;
	logic signed [33:0] cy_q;
	logic signed [19:0] cz_q;
	logic [23:0]        tan_q;
	logic [31:0]        rem_q;
	logic [45:0]        dvd_q;
	logic signed [15:0] yaw_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;

	function automatic logic signed [15:0] sat16(input logic signed [31:0] x);
		logic signed [15:0] r;
		if (x > 32'sd32767) r = 16'sh7fff;
		else if (x < -32'sd32768) r = 16'sh8000;
		else r = x[15:0];
		return r;
	endfunction

	function automatic logic [16:0] mag16(input logic signed [15:0] x);
		return x[15] ? (17'd0 - {x[15], x}) : {1'b0, x};
	endfunction

	// operand views
	logic signed [15:0] thr;
	logic               thr_pos;
	logic               ratio_on;
	logic [21:0]        ratio;
	logic signed [23:0] term;
	logic [23:0]        term_mag;
	logic [15:0]        limit;
	logic [70:0]        full;
	logic [17:0]        q;
	logic [18:0]        delta;
	logic signed [31:0] nv_sum;
	logic [29:0]        decay;
	logic signed [31:0] coast_dn;
	logic signed [31:0] coast_up;
	logic signed [15:0] coast_v;
	logic [19:0]        amag;
	logic [16:0]        angle;
	logic signed [33:0] cdx;
	logic signed [33:0] cdy;
	logic signed [19:0] atan_s;
	logic [31:0]        sqrt_bit;
	logic [32:0]        sqrt_t;
	logic [32:0]        div_sh;
	logic               div_ge;
	logic [16:0]        m_abs;
	logic [41:0]        ymag;
	logic               yneg;
	logic signed [15:0] yaw_val;
	logic signed [15:0] speed_val;
	logic [31:0]        pose_age;
	logic               out_free;

	assign thr      = item_q.throttle;
	assign thr_pos  = !thr[15] && (thr != 16'sd0);
	assign ratio_on = thr_pos ? (!speed_q[15] && (speed_q != 16'sd0)) : speed_q[15];
	assign ratio    = prod_q[31:10];
	assign term     = thr_pos ? ({{8{thr[15]}}, thr} - $signed({2'b00, ratio}))
	                          : ({{8{thr[15]}}, thr} + $signed({2'b00, ratio}));
	assign term_mag = term[23] ? (24'd0 - term) : term;
	assign limit    = thr_pos ? accel_q : brake_q;

	assign full   = {7'd0, acc_q} + {prod_q[38:0], 32'd0};
	assign q      = (full[70:47] != '0) ? DeltaSat : {1'b0, full[46:30]};
	assign delta  = neg_q ? (19'd0 - {1'b0, q}) : {1'b0, q};
	assign nv_sum = {{16{speed_q[15]}}, speed_q} + {{13{delta[18]}}, delta};

	assign decay    = prod_q[61:32];
	assign coast_dn = {{16{speed_q[15]}}, speed_q} - $signed({2'b00, decay});
	assign coast_up = {{16{speed_q[15]}}, speed_q} + $signed({2'b00, decay});
	always_comb begin
		if (!speed_q[15] && speed_q != 16'sd0)
			coast_v = coast_dn[31] ? 16'sd0 : coast_dn[15:0];
		else
			coast_v = (coast_up > 32'sd0) ? 16'sd0 : coast_up[15:0];
	end

	assign amag  = prod_q[31:12];
	assign angle = (amag > {3'd0, AngleClamp}) ? AngleClamp : amag[16:0];

	assign cdx    = cy_q >>> iter_q[3:0];
	assign cdy    = cx_q >>> iter_q[3:0];
	assign atan_s = $signed({4'd0, atan_lut(iter_q[3:0])});

	assign sqrt_bit = 32'h4000_0000 >> {iter_q[3:0], 1'b0};
	assign sqrt_t   = {1'b0, res_q} + {1'b0, sqrt_bit};

	assign div_sh = {rem_q, dvd_q[45]};
	assign div_ge = (div_sh >= {1'b0, cx_q[31:0]});

	// pose speed, signed by vel_x
	assign m_abs = res_q[16:0];
	always_comb begin
		if (res_q[31:17] != '0) speed_val = item_q.vel_x[15] ? 16'sh8000 : 16'sh7fff;
		else if (item_q.vel_x[15])
			speed_val = (m_abs > 17'd32768) ? 16'sh8000 : 16'(17'd0 - m_abs);
		else speed_val = (m_abs > 17'd32767) ? 16'sh7fff : m_abs[15:0];
	end

	assign ymag = prod_q[63:22];
	assign yneg = nv_q[15] != item_q.steering[15];
	always_comb begin
		if (yneg) yaw_val = (ymag > 42'd32768) ? 16'sh8000 : 16'(16'd0 - ymag[15:0]);
		else      yaw_val = (ymag > 42'd32767) ? 16'sh7fff : ymag[15:0];
	end

	assign pose_age = item_q.stamp - pose_time_q;
	assign out_free = !out_valid_q || out_ch.ready;
	assign pop      = (state_q == ST_IDLE) && head.valid;

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SQX: begin
				mul_a = {15'd0, mag16(item_q.vel_x)};
				mul_b = {15'd0, mag16(item_q.vel_x)};
			end
			ST_SQY: begin
				mul_a = {15'd0, mag16(item_q.vel_y)};
				mul_b = {15'd0, mag16(item_q.vel_y)};
			end
			ST_RATIO: begin
				mul_a = ratio_on ? {15'd0, mag16(speed_q)} : 32'd0;
				mul_b = {16'd0, inv_ms_q};
			end
			ST_TERM: begin
				mul_a = {16'd0, limit};
				mul_b = {8'd0, term_mag};
			end
			ST_MLO: begin
				mul_a = prod_q[31:0];
				mul_b = dt_q;
			end
			ST_MHI: begin
				mul_a = {26'd0, mag_q[37:32]};
				mul_b = dt_q;
			end
			ST_DEC1: begin
				mul_a = {16'd0, brake_q};
				mul_b = {18'd0, CoastFrac};
			end
			ST_DEC2: begin
				mul_a = prod_q[31:0];
				mul_b = dt_q;
			end
			ST_ANG: begin
				mul_a = {15'd0, mag16(item_q.steering)};
				mul_b = {17'd0, max_steer_q};
			end
			ST_YAW1: begin
				mul_a = {15'd0, mag16(nv_q)};
				mul_b = {16'd0, inv_wb_q};
			end
			ST_YAW2: begin
				mul_a = prod_q[31:0];
				mul_b = {8'd0, tan_q};
			end
			default: ;
		endcase
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.linear_velocity = out_vel_q;
	assign out_ch.yaw_rate        = out_yaw_q;

	// sequencer, configuration, persistent state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			inv_wb_q    <= InvWheelbaseRst;
			max_steer_q <= MaxSteerAngleRst;
			inv_ms_q    <= InvMaxSpeedRst;
			accel_q     <= AccelLimitRst;
			brake_q     <= BrakeLimitRst;
			timeout_q   <= PoseTimeoutRst;
			speed_q     <= '0;
			pose_time_q <= '0;
			cmd_time_q  <= '0;
			awaiting_q  <= 1'b1;
			pose_seen_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_vel_q   <= '0;
			out_yaw_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_INV_WHEELBASE:   inv_wb_q    <= cfg_data[15:0];
					REG_MAX_STEER_ANGLE: max_steer_q <= cfg_data[14:0];
					REG_INV_MAX_SPEED:   inv_ms_q    <= cfg_data[15:0];
					REG_ACCEL_LIMIT:     accel_q     <= cfg_data[15:0];
					REG_BRAKE_LIMIT:     brake_q     <= cfg_data[15:0];
					REG_POSE_TIMEOUT:    timeout_q   <= cfg_data[31:0];
					default: ;
				endcase
			end
			// the emit step reloads the register itself
			if (out_valid_q && out_ch.ready && state_q != ST_EMIT) out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: if (head.valid) state_q <= head.item.command ? ST_CHECK : ST_SQX;
				ST_SQX:  state_q <= ST_SQY;
				ST_SQY:  state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_SQRT;
				ST_SQRT: if (iter_q[3:0] == 4'(SqrtSteps - 1)) state_q <= ST_PSAVE;
				ST_PSAVE: begin
					speed_q     <= speed_val;
					pose_time_q <= item_q.stamp;
					pose_seen_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_CHECK: begin
					if (!pose_seen_q || pose_age > timeout_q) begin
						state_q <= ST_IDLE;
					end else if (awaiting_q) begin
						awaiting_q <= 1'b0;
						cmd_time_q <= item_q.stamp;
						state_q    <= ST_IDLE;
					end else begin
						state_q <= (thr == 16'sd0) ? ST_DEC1 : ST_RATIO;
					end
				end
				ST_RATIO:  state_q <= ST_TERM;
				ST_TERM:   state_q <= ST_MLO;
				ST_MLO:    state_q <= ST_MHI;
				ST_MHI:    state_q <= ST_DELTA;
				ST_DELTA:  state_q <= ST_ANG;
				ST_DEC1:   state_q <= ST_DEC2;
				ST_DEC2:   state_q <= ST_DEC3;
				ST_DEC3:   state_q <= ST_ANG;
				ST_ANG:    state_q <= ST_ANG2;
				ST_ANG2:   state_q <= ST_CORDIC;
				ST_CORDIC: if (iter_q[3:0] == 4'(CordicSteps - 1)) state_q <= ST_DIVSET;
				ST_DIVSET: state_q <= (cx_q[33] || cx_q == 34'sd0) ? ST_YAW1 : ST_DIV;
				ST_DIV:    if (iter_q == 6'(DivSteps - 1)) state_q <= ST_YAW1;
				ST_YAW1:   state_q <= ST_YAW2;
				ST_YAW2:   state_q <= ST_YAW3;
				ST_YAW3:   state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_vel_q   <= nv_q;
						out_yaw_q   <= yaw_q;
						cmd_time_q  <= item_q.stamp;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE:  if (head.valid) item_q <= head.item;
			ST_SQY:   acc_q <= prod_q;
			ST_SUM: begin
				n_q    <= acc_q[31:0] + prod_q[31:0];
				res_q  <= '0;
				iter_q <= '0;
			end
			ST_SQRT: begin
				if ({1'b0, n_q} >= sqrt_t) begin
					n_q   <= n_q - sqrt_t[31:0];
					res_q <= (res_q >> 1) + sqrt_bit;
				end else begin
					res_q <= res_q >> 1;
				end
				iter_q <= iter_q + 6'd1;
			end
			ST_CHECK: dt_q <= item_q.stamp - cmd_time_q;
			ST_TERM:  neg_q <= term[23];
			ST_MLO:   mag_q <= prod_q[37:0];
			ST_MHI:   acc_q <= prod_q;
			ST_DELTA: nv_q <= sat16(nv_sum);
			ST_DEC3:  nv_q <= coast_v;
			ST_ANG2: begin
				cx_q   <= $signed(CordicInitX);
				cy_q   <= '0;
				cz_q   <= $signed({3'd0, angle});
				iter_q <= '0;
			end
			ST_CORDIC: begin
				if (!cz_q[19]) begin
					cx_q <= cx_q - cdx;
					cy_q <= cy_q + cdy;
					cz_q <= cz_q - atan_s;
				end else begin
					cx_q <= cx_q + cdx;
					cy_q <= cy_q - cdy;
					cz_q <= cz_q + atan_s;
				end
				iter_q <= iter_q + 6'd1;
			end
			ST_DIVSET: begin
				// negative sine clips to zero, a non-positive cosine gives the overflow tan
				tan_q  <= (cx_q[33] || cx_q == 34'sd0) ? TanOverflow : 24'd0;
				dvd_q  <= cy_q[33] ? 46'd0 : {cy_q[31:0], 14'd0};
				rem_q  <= '0;
				iter_q <= '0;
			end
			ST_DIV: begin
				rem_q  <= div_ge ? 32'(div_sh - {1'b0, cx_q[31:0]}) : div_sh[31:0];
				tan_q  <= {tan_q[22:0], div_ge};
				dvd_q  <= {dvd_q[44:0], 1'b0};
				iter_q <= iter_q + 6'd1;
			end
			ST_YAW3: yaw_q <= yaw_val;
			default: ;
		endcase
	end

endmodule

[rtl/vehicle_speed_command_shaper_top.sv]
// top level of the vehicle speed command shaper
// Requests enter on in_ch: command = 0 is a pose (vel_x, vel_y, stamp), command = 1 is
// a throttle and steering command (throttle, steering, stamp). Results leave on out_ch
// as linear_velocity and yaw_rate, one per command with a timely pose, but the first.
// Registers are written through cfg_we / cfg_index / cfg_data, one per cycle.
// A two-entry queue sits behind in_ch, so requests are taken while the back end works.
// The back end handles one request at a time on a single 32x32 multiplier:
// a pose runs a 16-step square root; a command that produces a result runs a
// 16-step tan rotation and a 46-step divider, the divider is skipped when the
// tan overflows; a dropped or first command ends at its check.
// Results sit in an output register; while out_ch stalls, the finished result holds
// there and the back end waits in its emit step, the queue keeps filling until full.
// Reset clears the queue, the output register, the speed and times, marks no pose
// seen and the first command pending, and loads the register defaults.
module vehicle_speed_command_shaper_top (
	input  logic                          clk,
	input  logic                          arst_n,
	vscs_in_if.sink                       in_ch,
	vscs_out_if.source                    out_ch,
	input  logic                          cfg_we,
	input  logic [vscs_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [vscs_pkg::CfgDataW-1:0] cfg_data
);
	import vscs_pkg::*;

	queue_head_t head;
	logic        pop;

	vscs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.pop    (pop),
		.head   (head)
	);

	vscs_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ch    (out_ch)
	);

endmodule
